FILE: hdl/utf8d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [7:0] LEAD3_MASK = 8'hE0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] LEAD4_MASK = 8'hF0;
  localparam logic [7:0] LEAD5_MASK = 8'hF8;
  localparam logic [7:0] BITS2_MASK = 8'h1F;
  localparam logic [7:0] BITS3_MASK = 8'h0F;
  localparam logic [7:0] BITS4_MASK = 8'h07;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] CONT_BITS  = 8'h3F;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;

  localparam logic [CP_W-1:0] REPL_CP = CP_W'(8'h3F);

  // result queue
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CW    = $clog2(RQ_DEPTH + 1);

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            is_replacement;
    logic            last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
  } push_t;

endpackage

`default_nettype wire

FILE: hdl/utf8d_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface utf8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface utf8d_out_if;
  logic                       valid;
  logic                       ready;
  logic [utf8d_pkg::CP_W-1:0] code_point;
  logic                       is_replacement;
  logic                       last_of_run;

  modport source (output valid, output code_point, output is_replacement,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_point, input is_replacement,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: hdl/utf8_decoder_with_replacement.sv
// UTF-8 decoder with replacement.
// in_ch takes one text byte per beat (in_byte, end_of_text on the final
// byte of a text). out_ch gives decoded code points, one per beat, with
// is_replacement set on a '?' made by an error and last_of_run set on the
// final result caused by an input byte. A byte may cause zero, one or two
// results.
// An accepted byte is held in the input register, decoded from there into a
// 4-entry result queue and offered on out_ch from the queue.
// Throughput: one byte per cycle while each byte gives at most one result
// and out_ch takes every beat; a byte with two results takes two output
// beats, set by the single output port of the result queue. in_ready
// depends only on registers.
// Reset (rst_n low, synchronous) drops any open sequence, the held byte
// and queued results. When the receiver stalls the queue fills; decoding
// halts once fewer than two slots are free and in_ready falls after the
// input register fills. No beat is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module utf8_decoder_with_replacement (
  input  wire logic   clk,
  input  wire logic   rst_n,
  utf8d_in_if.sink    in_ch,
  utf8d_out_if.source out_ch
);

  logic             room;
  utf8d_pkg::push_t push;
  utf8d_pkg::res_t  res;

  utf8d_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.in_byte),
    .in_last  (in_ch.end_of_text),
    .room     (room),
    .push     (push)
  );

  utf8d_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.code_point     = res.code_point;
  assign out_ch.is_replacement = res.is_replacement;
  assign out_ch.last_of_run    = res.last_of_run;

endmodule

`default_nettype wire

FILE: hdl/utf8d_core.sv
`timescale 1ns / 1ps
`default_nettype none

module utf8d_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_byte,
  input  wire logic                in_last,
  input  wire logic                room,
  output utf8d_pkg::push_t         push
);

  localparam int unsigned W = utf8d_pkg::CP_W;

  logic         v_r, v_nxt;
  logic [7:0]   b_r;
  logic         last_r;
  logic [1:0]   rem_r, rem_nxt;
  logic [W-1:0] part_r, part_nxt;

  logic         load, consume;
  logic         in_seq, cont, ext, bad, done, open, main_en, cut;
  logic         lead2, lead3, lead4;
  logic [1:0]   rem_after, open_rem;
  logic [W-1:0] shifted, main_val, part_after, open_part;
  logic [1:0]   cnt;
  utf8d_pkg::res_t r_main, r_repl;

  assign load     = in_valid & in_ready;
  assign consume  = v_r & room;
  assign in_ready = ~v_r | room;

  always_comb begin
    in_seq  = (rem_r != 2'd0);
    cont    = ((b_r & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_TAG);
    ext     = in_seq & cont;
    bad     = in_seq & ~cont;
    done    = ext & (rem_r == 2'd1);
    shifted = {part_r[W-7:0], b_r[5:0]};

    lead2 = ((b_r & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD2_TAG);
    lead3 = ((b_r & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD3_TAG);
    lead4 = ((b_r & utf8d_pkg::LEAD5_MASK) == utf8d_pkg::LEAD4_TAG);
    open  = ~ext & (lead2 | lead3 | lead4);

    if (lead2) begin
      open_rem  = 2'd1;
      open_part = W'(b_r & utf8d_pkg::BITS2_MASK);
    end else if (lead3) begin
      open_rem  = 2'd2;
      open_part = W'(b_r & utf8d_pkg::BITS3_MASK);
    end else begin
      open_rem  = 2'd3;
      open_part = W'(b_r & utf8d_pkg::BITS4_MASK);
    end

    main_en  = done | (~ext & ~open);
    main_val = done ? shifted : W'(b_r);

    if (ext) begin
      rem_after  = 2'(rem_r - 2'd1);
      part_after = done ? '0 : shifted;
    end else if (open) begin
      rem_after  = open_rem;
      part_after = open_part;
    end else begin
      rem_after  = 2'd0;
      part_after = '0;
    end

    cut = last_r & (rem_after != 2'd0);
    cnt = 2'(bad) + 2'(main_en) + 2'(cut);

    r_main = '{code_point: main_val, is_replacement: 1'b0, last_of_run: 1'b0};
    r_repl = '{code_point: utf8d_pkg::REPL_CP, is_replacement: 1'b1, last_of_run: 1'b0};

    push.cnt  = consume ? cnt : 2'd0;
    push.res0 = (~bad & main_en) ? r_main : r_repl;
    push.res0.last_of_run = (cnt == 2'd1);
    push.res1 = (bad & main_en) ? r_main : r_repl;
    push.res1.last_of_run = 1'b1;

    v_nxt    = load | (v_r & ~consume);
    rem_nxt  = rem_r;
    part_nxt = part_r;
    if (consume) begin
      rem_nxt  = last_r ? 2'd0 : rem_after;
      part_nxt = last_r ? '0 : part_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= 1'b0;
      rem_r  <= 2'd0;
      part_r <= '0;
    end else begin
      v_r    <= v_nxt;
      rem_r  <= rem_nxt;
      part_r <= part_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b_r    <= in_byte;
      last_r <= in_last;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/utf8d_res_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module utf8d_res_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire utf8d_pkg::push_t push,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output utf8d_pkg::res_t       out_res
);

  localparam int unsigned AW = utf8d_pkg::RQ_AW;
  localparam int unsigned CW = utf8d_pkg::RQ_CW;

  utf8d_pkg::res_t mem_r [utf8d_pkg::RQ_DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_p1;
  logic [CW-1:0] occ_r, occ_nxt;
  logic          pop;

  // two free slots always left for one byte's worth of results
  assign room      = (occ_r <= CW'(utf8d_pkg::RQ_DEPTH - 2));
  assign out_valid = (occ_r != '0);
  assign out_res   = mem_r[rd_r];
  assign pop       = out_valid & out_ready;
  assign wr_p1     = AW'(wr_r + AW'(1));

  always_comb begin
    wr_nxt  = AW'(wr_r + AW'(push.cnt));
    rd_nxt  = pop ? AW'(rd_r + AW'(1)) : rd_r;
    occ_nxt = CW'(occ_r + CW'(push.cnt) - CW'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      occ_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_r] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_p1] <= push.res1;
    end
  end

endmodule

`default_nettype wire

FILE: tb/utf8d_decode_check.sv
`timescale 1ns / 1ps

module utf8d_decode_check (
  input  logic  clk,
  input  logic  rst_n,
  utf8d_in_if   in_mon,
  utf8d_out_if  out_mon,
  output int    fail_cnt,
  output int    pending
);

  logic [1:0]                 conts_left;
  logic [utf8d_pkg::CP_W-1:0] code_acc;
  utf8d_pkg::res_t            expected_cps[$];
  int                         errs;

  function automatic utf8d_pkg::res_t mk_cp(input logic [utf8d_pkg::CP_W-1:0] cp,
                                            input logic repl);
    utf8d_pkg::res_t r;
    r.code_point     = cp;
    r.is_replacement = repl;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic eot);
    utf8d_pkg::res_t runs[$];
    logic as_lead;
    as_lead = 1'b1;
    if (conts_left != 2'd0) begin
      if ((b & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_TAG) begin
        code_acc   = {code_acc[utf8d_pkg::CP_W-7:0], b[5:0]};
        conts_left = conts_left - 2'd1;
        if (conts_left == 2'd0) begin
          runs = {runs, mk_cp(code_acc, 1'b0)};
          code_acc = '0;
        end
        as_lead = 1'b0;
      end else begin
        runs = {runs, mk_cp(utf8d_pkg::REPL_CP, 1'b1)};
        conts_left = 2'd0;
        code_acc   = '0;
      end
    end
    if (as_lead) begin
      if ((b & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD2_TAG) begin
        code_acc   = utf8d_pkg::CP_W'(b & utf8d_pkg::BITS2_MASK);
        conts_left = 2'd1;
      end else if ((b & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD3_TAG) begin
        code_acc   = utf8d_pkg::CP_W'(b & utf8d_pkg::BITS3_MASK);
        conts_left = 2'd2;
      end else if ((b & utf8d_pkg::LEAD5_MASK) == utf8d_pkg::LEAD4_TAG) begin
        code_acc   = utf8d_pkg::CP_W'(b & utf8d_pkg::BITS4_MASK);
        conts_left = 2'd3;
      end else begin
        runs = {runs, mk_cp(utf8d_pkg::CP_W'(b), 1'b0)};
      end
    end
    if (eot) begin
      if (conts_left != 2'd0) begin
        runs = {runs, mk_cp(utf8d_pkg::REPL_CP, 1'b1)};
      end
      conts_left = 2'd0;
      code_acc   = '0;
    end
    if (runs.size() > 0) begin
      runs[runs.size()-1].last_of_run = 1'b1;
    end
    expected_cps = {expected_cps, runs};
  endtask

  always @(posedge clk) begin
    utf8d_pkg::res_t want;
    if (!rst_n) begin
      conts_left = 2'd0;
      code_acc   = '0;
      errs       = 0;
      expected_cps.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        decode_byte(in_mon.in_byte, in_mon.end_of_text);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_cps.size() == 0) begin
          errs++;
          $display("%0t: unexpected beat: expected none, actual cp=%0h repl=%0b last=%0b",
                   $time, out_mon.code_point, out_mon.is_replacement, out_mon.last_of_run);
        end else begin
          want = expected_cps.pop_front();
          if (out_mon.code_point !== want.code_point) begin
            errs++;
            $display("%0t: code_point: expected %0h, actual %0h",
                     $time, want.code_point, out_mon.code_point);
          end
          if (out_mon.is_replacement !== want.is_replacement) begin
            errs++;
            $display("%0t: is_replacement: expected %0b, actual %0b",
                     $time, want.is_replacement, out_mon.is_replacement);
          end
          if (out_mon.last_of_run !== want.last_of_run) begin
            errs++;
            $display("%0t: last_of_run: expected %0b, actual %0b",
                     $time, want.last_of_run, out_mon.last_of_run);
          end
        end
      end
    end
    fail_cnt <= errs;
    pending  <= expected_cps.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT = 300;
  localparam int CALM_TAIL = 150;
  localparam int TOTAL_BEATS = 1300;

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
  } text_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  utf8d_in_if  in_ch();
  utf8d_out_if out_ch();

  int fail_cnt;
  int pending;
  int idle_cycles = 0;
  int sent_cnt = 0;
  bit calm = 1'b0;
  bit holding = 1'b0;
  bit hold_done = 1'b0;

  text_beat_t text_beats[$];

  utf8_decoder_with_replacement i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  utf8d_decode_check i_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mon   (in_ch),
    .out_mon  (out_ch),
    .fail_cnt (fail_cnt),
    .pending  (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic add_beat(input logic [7:0] b, input logic eot);
    text_beat_t t;
    t.b   = b;
    t.eot = eot;
    text_beats = {text_beats, t};
  endtask

  // lead of an n_bytes sequence, then n_sent-1 continuation bytes
  task automatic add_seq(input int n_bytes, input int n_sent);
    logic [7:0] lead;
    lead = 8'($urandom_range(0, 255));
    case (n_bytes)
      2:       lead = 8'hC0 | (lead & 8'h1F);
      3:       lead = 8'hE0 | (lead & 8'h0F);
      default: lead = 8'hF0 | (lead & 8'h07);
    endcase
    add_beat(lead, 1'b0);
    for (int k = 1; k < n_sent; k++) begin
      add_beat(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
    end
  endtask

  task automatic add_random_text();
    int n_sym;
    int kind;
    int len;
    n_sym = $urandom_range(1, 12);
    for (int s = 0; s < n_sym; s++) begin
      kind = $urandom_range(0, 15);
      if (kind < 10) begin
        len = $urandom_range(1, 4);
        if (len == 1) add_beat(8'($urandom_range(0, 127)), 1'b0);
        else add_seq(len, len);
      end else if (kind < 13) begin
        len = $urandom_range(2, 4);
        add_seq(len, $urandom_range(1, len - 1));
      end else begin
        add_beat(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    text_beats[text_beats.size()-1].eot = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst_n && !((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      idle_cycles <= 0;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off, none at the tail
  initial begin
    out_ch.ready <= 1'b0;
    repeat (11) @(posedge clk);
    forever begin
      if (!hold_done && sent_cnt >= HOLD_AT) begin
        holding = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding   = 1'b0;
        hold_done = 1'b1;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [8:0] directed[];
    directed = '{
      9'h000, 9'h07F, 9'h03F, 9'h080, 9'h0F8, 9'h1FF,
      9'h0C3, 9'h0A9,
      9'h0E2, 9'h082, 9'h0AC,
      9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
      9'h0C3, 9'h041,
      9'h0E2, 9'h0F0, 9'h09F, 9'h098, 9'h080,
      9'h0E2, 9'h182,
      9'h0C3, 9'h1E2
    };
    foreach (directed[i]) add_beat(directed[i][7:0], directed[i][8]);
    while (text_beats.size() < TOTAL_BEATS) add_random_text();

    in_ch.valid       <= 1'b0;
    in_ch.in_byte     <= 8'h00;
    in_ch.end_of_text <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < text_beats.size(); i++) begin
      calm = (i >= text_beats.size() - CALM_TAIL);
      if (!calm && !holding && $urandom_range(0, 7) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      in_ch.valid       <= 1'b1;
      in_ch.in_byte     <= text_beats[i].b;
      in_ch.end_of_text <= text_beats[i].eot;
      do @(posedge clk); while (!in_ch.ready);
      sent_cnt = i + 1;
    end
    in_ch.valid <= 1'b0;

    // pending is a registered copy of the queue size, so it trails the last accepted beat
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
